// File: hdl/lcpa_pkg.sv
// ----------------------------------------------------------------------------
// LED chain pattern animator package
// Shared types, codes and the control program of the frame sequencer.
// ----------------------------------------------------------------------------
package lcpa_pkg;

    localparam int LED_COUNT_DEF = 30;

    localparam logic [9:0] INTERVAL_SLOW = 10'd1000;
    localparam logic [9:0] INTERVAL_MID  = 10'd500;
    localparam logic [9:0] INTERVAL_FAST = 10'd200;

    localparam logic [7:0] SPEED_SLOW = 8'd0;
    localparam logic [7:0] SPEED_FAST = 8'd2;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_START = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        MODE_STATIC  = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_MARQUEE = 2'd2,
        MODE_ROLL    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STEP_IDLE  = 2'd0,
        STEP_FRAME = 2'd1,
        STEP_DRAIN = 2'd2
    } t_step;

    typedef enum logic [1:0] {
        COND_ALWAYS  = 2'd0,
        COND_NO_WORK = 2'd1,
        COND_MORE    = 2'd2
    } t_cond;

    typedef struct packed {
        logic  busy;
        logic  issue;
        t_cond cond;
        t_step jump;
        t_step fall;
    } t_uop;

    function automatic t_uop uop_rom(input t_step step);
        t_uop uop;
        case (step)
            STEP_IDLE:  uop = '{busy: 1'b0, issue: 1'b0, cond: COND_NO_WORK,
                                jump: STEP_IDLE, fall: STEP_FRAME};
            STEP_FRAME: uop = '{busy: 1'b1, issue: 1'b1, cond: COND_MORE,
                                jump: STEP_FRAME, fall: STEP_DRAIN};
            STEP_DRAIN: uop = '{busy: 1'b1, issue: 1'b0, cond: COND_ALWAYS,
                                jump: STEP_IDLE, fall: STEP_IDLE};
            default:    uop = '{busy: 1'b1, issue: 1'b0, cond: COND_ALWAYS,
                                jump: STEP_IDLE, fall: STEP_IDLE};
        endcase
        return uop;
    endfunction

endpackage

// File: hdl/led_chain_pattern_animator.sv
// ----------------------------------------------------------------------------
// LED chain pattern animator
// Turns ticks, pattern loads and start commands into frames of colour codes.
// ----------------------------------------------------------------------------
// One input word is taken on a rising edge with start high and busy low. Its
// kind is a millisecond tick, a pattern-entry load or a start command.
// Loads, ticks that produce no frame and unknown requests leave busy low. A
// word that produces a frame raises busy from the accepting edge through the
// frame loop of the control program and its drain step; the loop issues one
// LED per cycle through the pattern memory read and the output register.
// After acceptance the LEDs follow in consecutive cycles, each on the result
// ports for exactly one cycle with o_result_strobe high; o_frame_last marks
// the final LED. The receiver cannot stall, so results are never held back.
// Reset (synchronous, active low) selects static mode, clears the timers,
// the animation length and the roll position; the pattern memories keep
// their contents, and a pattern entry must be loaded before a start command
// uses it.
// ----------------------------------------------------------------------------
module led_chain_pattern_animator #(
    parameter int LED_COUNT = lcpa_pkg::LED_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_req_type,
    input  logic [4:0] i_entry_index,
    input  logic [7:0] i_colour_code,
    input  logic [1:0] i_display_mode,
    input  logic [7:0] i_speed_code,
    input  logic [7:0] i_pattern_length,
    output logic       o_result_strobe,
    output logic [4:0] o_led_position,
    output logic [7:0] o_led_colour,
    output logic       o_frame_last
);
    import lcpa_pkg::*;

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int LEN_W = $clog2(LED_COUNT + 1);
    localparam int OFF_W = $clog2(LED_COUNT + 2);

    t_step r_step;
    t_step n_step;
    t_uop  w_uop;

    logic [7:0] r_stg_mem [LED_COUNT];
    logic [7:0] r_anim_mem [LED_COUNT];
    logic [7:0] r_stg_q;
    logic [7:0] r_anim_q;

    t_mode            r_mode;
    logic [LEN_W-1:0] r_stored_len;
    logic [OFF_W-1:0] r_roll_off;
    logic [9:0]       r_interval;
    logic [31:0]      r_elapsed;
    logic [LEN_W-1:0] r_base;

    logic [IDX_W-1:0] r_pos;
    logic [LEN_W-1:0] r_ptr;
    logic [LEN_W-1:0] r_skip;
    logic [LEN_W-1:0] r_frame_len;
    logic             r_tile;
    logic             r_blank;
    logic             r_copy;
    logic             r_src_anim;

    logic             r_s1_valid;
    logic             r_s1_zero;
    logic             r_s1_anim;
    logic             r_s1_wr;
    logic             r_s1_last;
    logic [IDX_W-1:0] r_s1_pos;
    logic [IDX_W-1:0] r_s1_addr;

    logic             w_accept;
    logic             w_frame_go;
    logic             w_stg_we;
    logic [31:0]      w_elapsed_inc;
    logic             w_animating;
    logic             w_due;
    logic [LEN_W-1:0] w_cmd_len;
    logic [LEN_W-1:0] w_ptr_inc;
    logic [LEN_W-1:0] w_base_inc;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_pos_last;
    logic             w_zero;
    logic             w_cond;

    assign w_uop    = uop_rom(r_step);
    assign busy     = w_uop.busy;
    assign w_accept = start && !w_uop.busy;

    assign w_elapsed_inc = r_elapsed + 32'd1;
    assign w_animating   = (r_mode == MODE_MARQUEE) || (r_mode == MODE_ROLL);
    assign w_due         = w_animating && (w_elapsed_inc > 32'(r_interval));
    assign w_cmd_len     = (32'(i_pattern_length) > 32'(LED_COUNT))
                           ? LEN_W'(LED_COUNT) : LEN_W'(i_pattern_length);
    assign w_stg_we      = w_accept && (i_req_type == REQ_LOAD)
                           && (32'(i_entry_index) < 32'(LED_COUNT));

    always_comb begin
        w_frame_go = 1'b0;
        case (i_req_type)
            REQ_TICK:  w_frame_go = w_due && !((r_mode == MODE_ROLL)
                                    && (r_roll_off > OFF_W'(LED_COUNT)));
            REQ_START: w_frame_go = 1'b1;
            default:   w_frame_go = 1'b0;
        endcase
    end

    assign w_ptr_inc  = r_ptr + 1'b1;
    assign w_base_inc = r_base + 1'b1;
    assign w_rd_addr  = IDX_W'(r_ptr);
    assign w_pos_last = (r_pos == IDX_W'(LED_COUNT - 1));
    assign w_zero     = r_blank || (r_skip != '0)
                        || (r_tile ? (r_frame_len == '0) : (r_ptr >= r_frame_len));

    // Control program sequencing.
    always_comb begin
        case (w_uop.cond)
            COND_ALWAYS:  w_cond = 1'b1;
            COND_NO_WORK: w_cond = !(w_accept && w_frame_go);
            COND_MORE:    w_cond = !w_pos_last;
            default:      w_cond = 1'b1;
        endcase
        n_step = w_cond ? w_uop.jump : w_uop.fall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Request decode and animation state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_STATIC;
            r_stored_len <= '0;
            r_roll_off   <= '0;
            r_interval   <= '0;
            r_elapsed    <= '0;
            r_base       <= '0;
        end else if (w_accept) begin
            case (i_req_type)
                REQ_TICK: begin
                    r_elapsed <= w_due ? '0 : w_elapsed_inc;
                    if (w_due && (r_mode == MODE_ROLL)) begin
                        if (r_roll_off > OFF_W'(LED_COUNT)) begin
                            r_mode     <= MODE_STATIC;
                            r_roll_off <= '0;
                        end else begin
                            r_roll_off <= r_roll_off + 1'b1;
                        end
                    end else if (w_due) begin
                        r_base <= (w_base_inc >= r_stored_len) ? '0 : w_base_inc;
                    end
                end
                REQ_START: begin
                    r_mode <= t_mode'(i_display_mode);
                    if ((i_display_mode == MODE_MARQUEE) || (i_display_mode == MODE_ROLL)) begin
                        r_stored_len <= w_cmd_len;
                        r_roll_off   <= '0;
                        r_base       <= '0;
                        if (i_speed_code == SPEED_SLOW) begin
                            r_interval <= INTERVAL_SLOW;
                        end else if (i_speed_code == SPEED_FAST) begin
                            r_interval <= INTERVAL_FAST;
                        end else begin
                            r_interval <= INTERVAL_MID;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Frame address generation.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_frame_go) begin
            r_pos <= '0;
            if (i_req_type == REQ_TICK) begin
                r_frame_len <= r_stored_len;
                r_src_anim  <= 1'b1;
                r_blank     <= 1'b0;
                r_copy      <= 1'b0;
                if (r_mode == MODE_ROLL) begin
                    r_tile <= 1'b0;
                    r_ptr  <= '0;
                    r_skip <= LEN_W'(r_roll_off);
                end else begin
                    r_tile <= 1'b1;
                    r_ptr  <= r_base;
                    r_skip <= '0;
                end
            end else begin
                r_frame_len <= w_cmd_len;
                r_src_anim  <= 1'b0;
                r_ptr       <= '0;
                r_skip      <= '0;
                r_tile      <= (i_display_mode == MODE_REPEAT);
                r_blank     <= (i_display_mode == MODE_MARQUEE)
                               || (i_display_mode == MODE_ROLL);
                r_copy      <= (i_display_mode == MODE_MARQUEE)
                               || (i_display_mode == MODE_ROLL);
            end
        end else if (w_uop.issue) begin
            r_pos <= r_pos + 1'b1;
            if (r_skip != '0) begin
                r_skip <= r_skip - 1'b1;
            end else if (r_tile) begin
                r_ptr <= (w_ptr_inc >= r_frame_len) ? '0 : w_ptr_inc;
            end else begin
                r_ptr <= w_ptr_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stg_we) begin
            r_stg_mem[IDX_W'(i_entry_index)] <= i_colour_code;
        end
        r_stg_q <= r_stg_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_wr) begin
            r_anim_mem[r_s1_addr] <= r_stg_q;
        end
        r_anim_q <= r_anim_mem[w_rd_addr];
    end

    // Read stage and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_s1_wr         <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            r_s1_valid      <= w_uop.issue;
            r_s1_wr         <= w_uop.issue && r_copy && (r_ptr < r_frame_len);
            o_result_strobe <= r_s1_valid;
        end
        r_s1_zero      <= w_zero;
        r_s1_anim      <= r_src_anim;
        r_s1_last      <= w_pos_last;
        r_s1_pos       <= r_pos;
        r_s1_addr      <= w_rd_addr;
        o_led_position <= 5'(r_s1_pos);
        o_frame_last   <= r_s1_last;
        o_led_colour   <= r_s1_zero ? 8'd0 : (r_s1_anim ? r_anim_q : r_stg_q);
    end

endmodule

// File: test/lcpa_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED frame checker
// Watches the command and LED channels of the pattern animator. It keeps its
// own copy of the patterns, mode and timers, works out every frame from the
// accepted words, and compares each LED word field by field with the oldest
// one still expected.
// ----------------------------------------------------------------------------
module lcpa_frame_checker #(
    parameter int LED_COUNT = lcpa_pkg::LED_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_req_type,
    input  logic [4:0] i_entry_index,
    input  logic [7:0] i_colour_code,
    input  logic [1:0] i_display_mode,
    input  logic [7:0] i_speed_code,
    input  logic [7:0] i_pattern_length,
    input  logic       i_result_strobe,
    input  logic [4:0] i_led_position,
    input  logic [7:0] i_led_colour,
    input  logic       i_frame_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_frames
);
    import lcpa_pkg::*;

    typedef logic [LED_COUNT-1:0][7:0] t_frame;

    typedef struct packed {
        logic [4:0] position;
        logic [7:0] colour;
        logic       last;
    } t_led_word;

    t_frame      staged_pattern;
    t_frame      anim_pattern;
    t_mode       shown_mode;
    int          anim_length;
    int          roll_shift;
    logic [9:0]  period_ms;
    logic [31:0] now_ms;
    logic [31:0] last_frame_ms;
    t_led_word   led_words[$];
    t_led_word   oldest_word;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_frames     = 0;
    end

    function automatic t_frame tile_pattern(input t_frame src, input int length);
        t_frame frame;
        int     j;
        j = 0;
        for (int p = 0; p < LED_COUNT; p++) begin
            frame[p] = (length == 0) ? 8'd0 : src[j];
            j++;
            if (j >= length) begin
                j = 0;
            end
        end
        return frame;
    endfunction

    task automatic queue_frame(input t_frame frame);
        for (int p = 0; p < LED_COUNT; p++) begin
            led_words.push_back('{position: 5'(p), colour: frame[p],
                                  last: (p == LED_COUNT - 1)});
        end
        o_frames++;
    endtask

    task automatic predict_word(input logic [1:0] req, input logic [4:0] index,
                                input logic [7:0] colour, input logic [1:0] mode,
                                input logic [7:0] speed, input logic [7:0] length);
        t_frame     frame;
        int         count;
        logic [7:0] head;
        frame = '0;
        case (req)
            REQ_TICK: begin
                now_ms = now_ms + 32'd1;
                if ((shown_mode == MODE_MARQUEE || shown_mode == MODE_ROLL)
                        && (now_ms - last_frame_ms) > {22'd0, period_ms}) begin
                    last_frame_ms = now_ms;
                    if (shown_mode == MODE_MARQUEE) begin
                        queue_frame(tile_pattern(anim_pattern, anim_length));
                        if (anim_length > 1) begin
                            head = anim_pattern[0];
                            for (int p = 0; p < anim_length - 1; p++) begin
                                anim_pattern[p] = anim_pattern[p + 1];
                            end
                            anim_pattern[anim_length - 1] = head;
                        end
                    end else if (roll_shift > LED_COUNT) begin
                        shown_mode = MODE_STATIC;
                        roll_shift = 0;
                    end else begin
                        for (int p = 0; p < LED_COUNT; p++) begin
                            if (p >= roll_shift && p - roll_shift < anim_length) begin
                                frame[p] = anim_pattern[p - roll_shift];
                            end
                        end
                        roll_shift++;
                        queue_frame(frame);
                    end
                end
            end
            REQ_LOAD: begin
                if (index < LED_COUNT) begin
                    staged_pattern[index] = colour;
                end
            end
            REQ_START: begin
                count = (length > LED_COUNT) ? LED_COUNT : int'(length);
                shown_mode = t_mode'(mode);
                case (shown_mode)
                    MODE_STATIC: begin
                        for (int p = 0; p < count; p++) begin
                            frame[p] = staged_pattern[p];
                        end
                        queue_frame(frame);
                    end
                    MODE_REPEAT: begin
                        queue_frame(tile_pattern(staged_pattern, count));
                    end
                    default: begin
                        anim_length = count;
                        if (speed == SPEED_SLOW) begin
                            period_ms = INTERVAL_SLOW;
                        end else if (speed == SPEED_FAST) begin
                            period_ms = INTERVAL_FAST;
                        end else begin
                            period_ms = INTERVAL_MID;
                        end
                        anim_pattern = '0;
                        for (int p = 0; p < count; p++) begin
                            anim_pattern[p] = staged_pattern[p];
                        end
                        roll_shift = 0;
                        queue_frame(frame);
                    end
                endcase
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            staged_pattern = '0;
            anim_pattern   = '0;
            shown_mode     = MODE_STATIC;
            anim_length    = 0;
            roll_shift     = 0;
            period_ms      = '0;
            now_ms         = '0;
            last_frame_ms  = '0;
            led_words.delete();
        end else begin
            if (i_result_strobe) begin
                if (led_words.size() == 0) begin
                    $error("LED word at position %0d arrived with no frame expected",
                           i_led_position);
                    o_fail_count++;
                end else begin
                    oldest_word = led_words.pop_front();
                    if (i_led_position !== oldest_word.position) begin
                        $error("led_position: expected %0d, got %0d",
                               oldest_word.position, i_led_position);
                        o_fail_count++;
                    end
                    if (i_led_colour !== oldest_word.colour) begin
                        $error("led_colour: expected %0d, got %0d",
                               oldest_word.colour, i_led_colour);
                        o_fail_count++;
                    end
                    if (i_frame_last !== oldest_word.last) begin
                        $error("frame_last: expected %0d, got %0d",
                               oldest_word.last, i_frame_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_word(i_req_type, i_entry_index, i_colour_code, i_display_mode,
                             i_speed_code, i_pattern_length);
            end
        end
        o_pending = led_words.size();
    end

endmodule

// File: test/tb_led_chain_pattern_animator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED chain pattern animator testbench
// Drives ticks, pattern loads and start commands into the animator, first a
// short directed set and then random scenes of loads, a start command and a
// run of ticks, under changing sender idling. The frame checker predicts and
// compares every LED word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_led_chain_pattern_animator;
    import lcpa_pkg::*;

    localparam int         LED_COUNT      = LED_COUNT_DEF;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 270;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_req_type;
    logic [4:0] i_entry_index;
    logic [7:0] i_colour_code;
    logic [1:0] i_display_mode;
    logic [7:0] i_speed_code;
    logic [7:0] i_pattern_length;
    logic       o_result_strobe;
    logic [4:0] o_led_position;
    logic [7:0] o_led_colour;
    logic       o_frame_last;

    int fail_count;
    int pending_words;
    int frames_seen;

    int                   idle_pct;
    int                   quiet_cycles;
    int                   loads_sent;
    int                   starts_sent;
    int                   ticks_sent;
    int                   unused_sent;
    logic [LED_COUNT-1:0] loaded;
    int                   loaded_run;

    always #10 i_clk = ~i_clk;

    led_chain_pattern_animator #(
        .LED_COUNT(LED_COUNT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_colour_code   (i_colour_code),
        .i_display_mode  (i_display_mode),
        .i_speed_code    (i_speed_code),
        .i_pattern_length(i_pattern_length),
        .o_result_strobe (o_result_strobe),
        .o_led_position  (o_led_position),
        .o_led_colour    (o_led_colour),
        .o_frame_last    (o_frame_last)
    );

    lcpa_frame_checker #(
        .LED_COUNT(LED_COUNT)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_colour_code   (i_colour_code),
        .i_display_mode  (i_display_mode),
        .i_speed_code    (i_speed_code),
        .i_pattern_length(i_pattern_length),
        .i_result_strobe (o_result_strobe),
        .i_led_position  (o_led_position),
        .i_led_colour    (o_led_colour),
        .i_frame_last    (o_frame_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words),
        .o_frames        (frames_seen)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d cycles without progress.", quiet_cycles);
                $display("led_chain_pattern_animator test failed");
                $finish;
            end
        end
    end

    function automatic int frame_period(input logic [7:0] speed);
        if (speed == SPEED_SLOW) begin
            return int'(INTERVAL_SLOW);
        end else if (speed == SPEED_FAST) begin
            return int'(INTERVAL_FAST);
        end
        return int'(INTERVAL_MID);
    endfunction

    task automatic send_word(input logic [1:0] req, input logic [4:0] index,
                             input logic [7:0] colour, input logic [1:0] mode,
                             input logic [7:0] speed, input logic [7:0] length);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start            <= 1'b1;
        i_req_type       <= req;
        i_entry_index    <= index;
        i_colour_code    <= colour;
        i_display_mode   <= mode;
        i_speed_code     <= speed;
        i_pattern_length <= length;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(REQ_TICK, 5'($urandom_range(31)), 8'($urandom_range(255)),
                      2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        end
        ticks_sent += count;
    endtask

    task automatic load_entry(input logic [4:0] index, input logic [7:0] colour);
        send_word(REQ_LOAD, index, colour, 2'($urandom_range(3)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        loads_sent++;
        if (index < LED_COUNT) begin
            loaded[index] = 1'b1;
        end
        while (loaded_run < LED_COUNT && loaded[loaded_run]) begin
            loaded_run++;
        end
    endtask

    task automatic start_show(input t_mode mode, input logic [7:0] speed,
                              input logic [7:0] length);
        send_word(REQ_START, 5'($urandom_range(31)), 8'($urandom_range(255)), mode, speed,
                  length);
        starts_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_words != 0);
    endtask

    task automatic run_scene();
        int         period;
        int         ticks;
        logic       to_roll_end;
        logic [4:0] index;
        t_mode      mode;
        logic [7:0] speed;
        logic [7:0] length;
        for (int n = $urandom_range(5); n > 0; n--) begin
            if (loaded_run < LED_COUNT && $urandom_range(1) == 0) begin
                index = 5'(loaded_run);
            end else begin
                index = 5'($urandom_range(31));
            end
            load_entry(index, 8'($urandom_range(255)));
        end
        if ($urandom_range(19) == 0) begin
            send_word(REQ_UNUSED, 5'($urandom_range(31)), 8'($urandom_range(255)),
                      2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
            unused_sent++;
        end
        if ($urandom_range(9) == 0) begin
            send_ticks($urandom_range(1, 20));
        end
        if (loaded_run == LED_COUNT) begin
            case ($urandom_range(3))
                0:       length = 8'($urandom_range(255));
                1:       length = 8'd255;
                default: length = 8'($urandom_range(LED_COUNT + 1));
            endcase
        end else begin
            length = 8'($urandom_range(loaded_run));
        end
        case ($urandom_range(9))
            0:             speed = SPEED_SLOW;
            1, 2, 3, 4, 5: speed = SPEED_FAST;
            6, 7:          speed = 8'd1;
            default:       speed = 8'($urandom_range(255));
        endcase
        mode = t_mode'($urandom_range(3));
        to_roll_end = (mode == MODE_ROLL) && ($urandom_range(7) == 0);
        if (to_roll_end) begin
            speed = SPEED_FAST;
        end
        start_show(mode, speed, length);
        if (mode == MODE_MARQUEE || mode == MODE_ROLL) begin
            period = frame_period(speed);
            if (to_roll_end) begin
                ticks = (LED_COUNT + 2) * (period + 1) + 2;
            end else begin
                ticks = $urandom_range(1, 3) * (period + 1) + $urandom_range(period);
            end
            send_ticks(ticks);
        end
        if ($urandom_range(3) == 0) begin
            wait_drained();
        end
    endtask

    initial begin
        int scene_count;
        int item_base;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_req_type       = REQ_TICK;
        i_entry_index    = '0;
        i_colour_code    = '0;
        i_display_mode   = MODE_STATIC;
        i_speed_code     = '0;
        i_pattern_length = '0;
        quiet_cycles     = 0;
        loads_sent       = 0;
        starts_sent      = 0;
        ticks_sent       = 0;
        unused_sent      = 0;
        loaded           = '0;
        loaded_run       = 0;
        idle_pct         = 18;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_ticks(1);
        send_word(REQ_UNUSED, 5'd31, 8'd255, MODE_ROLL, 8'd255, 8'd255);
        unused_sent++;
        start_show(MODE_STATIC, 8'd255, 8'd0);
        start_show(MODE_REPEAT, 8'd1, 8'd0);
        load_entry(5'd0, 8'd255);
        load_entry(5'd1, 8'd0);
        load_entry(5'd2, 8'h5a);
        load_entry(5'd30, 8'haa);
        load_entry(5'd31, 8'h55);
        load_entry(5'd29, 8'ha5);
        start_show(MODE_STATIC, 8'd1, 8'd3);
        start_show(MODE_REPEAT, 8'd255, 8'd1);
        start_show(MODE_REPEAT, 8'd2, 8'd3);
        start_show(MODE_MARQUEE, SPEED_SLOW, 8'd0);
        send_ticks(frame_period(SPEED_SLOW) + 3);
        start_show(MODE_MARQUEE, SPEED_FAST, 8'd3);
        send_ticks(3 * (frame_period(SPEED_FAST) + 1) + 2);
        start_show(MODE_ROLL, SPEED_FAST, 8'd3);
        send_ticks((LED_COUNT + 2) * (frame_period(SPEED_FAST) + 1) + 2);
        wait_drained();

        scene_count = 0;
        item_base   = loads_sent + unused_sent + frames_seen;
        while (loads_sent + unused_sent + frames_seen - item_base < RANDOM_ITEMS) begin
            case ((scene_count / 5) % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 60;
                2:       idle_pct = 0;
                default: idle_pct = 18;
            endcase
            run_scene();
            scene_count++;
        end

        wait_drained();
        repeat (LED_COUNT + 8) @(negedge i_clk);
        $display("Sent %0d loads, %0d start commands, %0d ticks and %0d unused requests.",
                 loads_sent, starts_sent, ticks_sent, unused_sent);
        $display("Compared %0d frames of %0d LEDs over static, repeat, marquee and roll.",
                 frames_seen, LED_COUNT);
        if (fail_count == 0 && pending_words == 0) begin
            $display("led_chain_pattern_animator test passed");
        end else begin
            $display("led_chain_pattern_animator test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/lcpa_pkg.sv
hdl/led_chain_pattern_animator.sv
test/lcpa_frame_checker.sv
test/tb_led_chain_pattern_animator.sv
